// ===== rtl/dctcp_ae_pkg.sv =====
// ----------------------------------------------------------------------------
// dctcp_ae_pkg
// Shared widths, fixed-point constants and types for the DCTCP alpha estimator.
// ----------------------------------------------------------------------------
package dctcp_ae_pkg;

	localparam int unsigned SEQ_W       = 32;  // sequence numbers and cwnd
	localparam int unsigned Q_W         = 17;  // Q1.16 values
	localparam int unsigned CFG_W       = 17;  // widest config register
	localparam int unsigned MP_W        = 18;  // serial multiplier operand
	localparam int unsigned MC_W        = 34;  // parallel multiplicand, signed
	localparam int unsigned ACC_W       = 35;  // product accumulator, signed
	localparam int unsigned STEP_W      = 5;   // step counter of the serial units
	localparam int unsigned IN_TDATA_W  = 96;
	localparam int unsigned OUT_FIELD_W = 2 * Q_W + SEQ_W;
	localparam int unsigned OUT_TDATA_W = 72;

	localparam logic [Q_W-1:0]    ONE_Q16    = 17'h10000;
	localparam logic [Q_W-1:0]    GAIN_RESET = 17'h01000;
	localparam logic [MP_W-1:0]   TWO_Q16    = 18'h20000;

	// Step counts less one
	localparam logic [STEP_W-1:0] DIV_STEPS_M1  = 5'd16;
	localparam logic [STEP_W-1:0] EWMA_STEPS_M1 = 5'd16;
	localparam logic [STEP_W-1:0] SS_STEPS_M1   = 5'd17;

	typedef enum logic [0:0] {
		CFG_GAIN       = 1'b0,
		CFG_ALPHA_INIT = 1'b1
	} cfg_reg_t;

	typedef logic signed [MC_W-1:0]  mcand_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps_m1;
	} mul_ctl_t;

endpackage

// ===== rtl/dctcp_ae_div.sv =====
// ----------------------------------------------------------------------------
// dctcp_ae_div
// Bit-serial restoring divider: floor(num * 2^16 / den), num <= den.
// ----------------------------------------------------------------------------
module dctcp_ae_div #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [COUNT_BITS-1:0]        num,
	input  logic [COUNT_BITS-1:0]        den,
	output logic [dctcp_ae_pkg::Q_W-1:0] quo,
	output logic                         done
);
	import dctcp_ae_pkg::*;

	logic [COUNT_BITS:0]   rem_q;
	logic [COUNT_BITS-1:0] den_q;
	logic [Q_W-1:0]        quo_q;
	logic [STEP_W-1:0]     cnt_q;
	logic                  first_q;
	logic                  busy_q;
	logic                  done_q;
	logic [COUNT_BITS:0]   trial;
	logic                  fits;

	// first step takes the quotient's integer bit without doubling
	assign trial = first_q ? rem_q : {rem_q[COUNT_BITS-1:0], 1'b0};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			den_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
			first_q <= 1'b0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else if (start) begin
			rem_q   <= {1'b0, num};
			den_q   <= den;
			quo_q   <= '0;
			cnt_q   <= DIV_STEPS_M1;
			first_q <= 1'b1;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else if (busy_q) begin
			rem_q   <= fits ? trial - {1'b0, den_q} : trial;
			quo_q   <= {quo_q[Q_W-2:0], fits};
			first_q <= 1'b0;
			cnt_q   <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// ===== rtl/dctcp_ae_mul.sv =====
// ----------------------------------------------------------------------------
// dctcp_ae_mul
// Shared bit-serial shift-add multiplier, LSB first, floor-scaled result.
// ----------------------------------------------------------------------------
module dctcp_ae_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dctcp_ae_pkg::mul_ctl_t        ctl,
	input  dctcp_ae_pkg::mcand_t          mcand,
	input  logic [dctcp_ae_pkg::MP_W-1:0] mplier,
	output dctcp_ae_pkg::acc_t            prod,
	output logic                          done
);
	import dctcp_ae_pkg::*;

	// Every step but the last halves the sum, so the result is
	// floor(mcand * mplier / 2^steps_m1).
	mcand_t            mc_q;
	logic [MP_W-1:0]   mp_q;
	acc_t              acc_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	acc_t              pp;
	acc_t              sum;

	assign pp  = mp_q[0] ? acc_t'(mc_q) : '0;
	assign sum = acc_q + pp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mc_q   <= '0;
			mp_q   <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (ctl.start) begin
			mc_q   <= mcand;
			mp_q   <= mplier;
			acc_q  <= '0;
			cnt_q  <= ctl.steps_m1;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			mp_q  <= {1'b0, mp_q[MP_W-1:1]};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				acc_q  <= sum;
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				acc_q <= sum >>> 1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

// ===== rtl/dctcp_alpha_estimator.sv =====
// ----------------------------------------------------------------------------
// dctcp_alpha_estimator
// DCTCP congestion extent (alpha) EWMA with ssthresh, one result beat per ACK.
// ----------------------------------------------------------------------------
// Flow: a new ACK is taken only after the result beat of the last one is
//   loaded; each ACK runs the shared 18-step serial multiplier, and a window
//   close also runs the 17-step serial divider and a 17-step multiply.
// Reset: arst_n clears all state at once; gain 0.0625, alpha 1.0, counters 0,
//   window end not latched. No clearing pass.
// ----------------------------------------------------------------------------
module dctcp_alpha_estimator #(
	parameter int unsigned COUNT_BITS = 16   // ACK counter width, 8..32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// ACK event in
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [31:0] last_acked_seq, [63:32] next_tx_seq, [95:64] cwnd
	input  logic [dctcp_ae_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [0] ece_marked
	input  logic                                 s_tuser,
	// Estimate out
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [16:0] alpha_now, [48:17] ssthresh, [65:49] marked_fraction, [71:66] zero
	output logic [dctcp_ae_pkg::OUT_TDATA_W-1:0] m_tdata,
	// [0] window_closed
	output logic                                 m_tuser,
	// Configuration writes
	input  logic                                 cfg_we,
	input  dctcp_ae_pkg::cfg_reg_t               cfg_index,
	input  logic [dctcp_ae_pkg::CFG_W-1:0]       cfg_data
);
	import dctcp_ae_pkg::*;

	// Sequencer: IDLE takes a beat and, on a window close, kicks the divider.
	// DIV waits for the marked fraction, EWMA runs g*(F - alpha) on the shared
	// multiplier, SSL/SS run cwnd*(2 - alpha), OUT waits for the output register.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_EWMA,
		ST_SSL,
		ST_SS,
		ST_OUT
	} state_t;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	state_t                  state_q;
	logic [Q_W-1:0]          gain_q;
	logic [Q_W-1:0]          alpha_q;
	logic [COUNT_BITS-1:0]   mark_cnt_q;
	logic [COUNT_BITS-1:0]   ack_cnt_q;
	logic [SEQ_W-1:0]        wend_q;
	logic                    wend_vld_q;
	logic [SEQ_W-1:0]        cwnd_q;
	logic                    closed_q;
	logic [Q_W-1:0]          frac_q;
	logic [SEQ_W-1:0]        ss_q;
	logic                    m_tvalid_q;
	logic [OUT_TDATA_W-1:0]  m_tdata_q;
	logic                    m_tuser_q;

	logic                    accept;
	logic [SEQ_W-1:0]        acked;
	logic [SEQ_W-1:0]        nxt;
	logic [SEQ_W-1:0]        cwnd_in;
	logic [COUNT_BITS-1:0]   mark_inc;
	logic [COUNT_BITS-1:0]   ack_inc;
	logic [SEQ_W-1:0]        wend;
	logic                    closing;
	logic                    out_free;

	logic [Q_W-1:0]          div_quo;
	logic                    div_done;
	logic [Q_W-1:0]          frac_cl;
	logic [Q_W-1:0]          gain_cl;
	logic [Q_W-1:0]          cfg_alpha_cl;
	logic signed [MP_W-1:0]  frac_diff;

	mul_ctl_t                mul_ctl;
	mcand_t                  mul_mcand;
	logic [MP_W-1:0]         mul_mplier;
	acc_t                    mul_prod;
	logic                    mul_done;
	acc_t                    alpha_sum;
	logic [Q_W-1:0]          alpha_new;

	assign acked   = s_tdata[SEQ_W-1:0];
	assign nxt     = s_tdata[2*SEQ_W-1:SEQ_W];
	assign cwnd_in = s_tdata[3*SEQ_W-1:2*SEQ_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Saturating counts including this ACK
	assign mark_inc = (s_tuser && (mark_cnt_q != CNT_MAX)) ? mark_cnt_q + 1'b1 : mark_cnt_q;
	assign ack_inc  = (ack_cnt_q != CNT_MAX) ? ack_cnt_q + 1'b1 : ack_cnt_q;

	// First ACK latches the window end before the compare
	assign wend    = wend_vld_q ? wend_q : nxt;
	assign closing = acked >= wend;

	dctcp_ae_div #(
		.COUNT_BITS(COUNT_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && closing),
		.num    (mark_inc),
		.den    (ack_inc),
		.quo    (div_quo),
		.done   (div_done)
	);

	assign frac_cl      = (div_quo > ONE_Q16) ? ONE_Q16 : div_quo;
	assign gain_cl      = (gain_q > ONE_Q16) ? ONE_Q16 : gain_q;
	assign cfg_alpha_cl = (cfg_data > ONE_Q16) ? ONE_Q16 : cfg_data;

	// alpha' = alpha + floor(g * (F - alpha) / 2^16), exact for the EWMA form
	assign frac_diff = $signed({1'b0, frac_cl}) - $signed({1'b0, alpha_q});

	always_comb begin
		mul_ctl    = '0;
		mul_mcand  = '0;
		mul_mplier = '0;
		unique case (state_q)
			ST_DIV: begin
				mul_ctl.start    = div_done;
				mul_ctl.steps_m1 = EWMA_STEPS_M1;
				mul_mcand        = mcand_t'(frac_diff);
				mul_mplier       = {1'b0, gain_cl};
			end
			ST_SSL: begin
				// ssthresh = floor(cwnd * (2^17 - alpha) / 2^17)
				mul_ctl.start    = 1'b1;
				mul_ctl.steps_m1 = SS_STEPS_M1;
				mul_mcand        = mcand_t'({2'b00, cwnd_q});
				mul_mplier       = TWO_Q16 - {1'b0, alpha_q};
			end
			default: begin
			end
		endcase
	end

	dctcp_ae_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.mcand  (mul_mcand),
		.mplier (mul_mplier),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	assign alpha_sum = acc_t'({1'b0, alpha_q}) + mul_prod;

	always_comb begin
		priority if (alpha_sum[ACC_W-1]) begin
			alpha_new = '0;
		end else if (alpha_sum > acc_t'({1'b0, ONE_Q16})) begin
			alpha_new = ONE_Q16;
		end else begin
			alpha_new = alpha_sum[Q_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			gain_q     <= GAIN_RESET;
			alpha_q    <= ONE_Q16;
			mark_cnt_q <= '0;
			ack_cnt_q  <= '0;
			wend_q     <= '0;
			wend_vld_q <= 1'b0;
			cwnd_q     <= '0;
			closed_q   <= 1'b0;
			frac_q     <= '0;
			ss_q       <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
		end else begin
			// new beat loads the output register, else a taken beat drops
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			// config must only arrive while idle; the block itself does not enforce this
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_GAIN:       gain_q  <= cfg_data;
					CFG_ALPHA_INIT: alpha_q <= cfg_alpha_cl;
					default: begin
					end
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mark_cnt_q <= closing ? '0 : mark_inc;
						ack_cnt_q  <= closing ? '0 : ack_inc;
						wend_q     <= closing ? nxt : wend;
						wend_vld_q <= 1'b1;
						cwnd_q     <= cwnd_in;
						closed_q   <= closing;
						frac_q     <= '0;
						state_q    <= closing ? ST_DIV : ST_SSL;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						frac_q  <= frac_cl;
						state_q <= ST_EWMA;
					end
				end
				ST_EWMA: begin
					if (mul_done) begin
						alpha_q <= alpha_new;
						state_q <= ST_SSL;
					end
				end
				ST_SSL: begin
					state_q <= ST_SS;
				end
				ST_SS: begin
					if (mul_done) begin
						ss_q    <= mul_prod[SEQ_W-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tdata_q  <= {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, frac_q, ss_q, alpha_q};
						m_tuser_q  <= closed_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== rtl/dctcp_ae_chk.sv =====
// ----------------------------------------------------------------------------
// dctcp_ae_chk
// Port-level checks for the DCTCP alpha estimator, bound to the top level.
// ----------------------------------------------------------------------------
module dctcp_ae_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [dctcp_ae_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                                 m_tuser
);
	import dctcp_ae_pkg::*;

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// one ACK in flight: ready drops after a beat is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second ACK taken while one is in flight");

	// alpha stays within [0, 1.0]
	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[Q_W-1:0] <= ONE_Q16)
		else $error("alpha above one");

	// fraction reported only for a closed window
	a_frac_open: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[OUT_FIELD_W-1:Q_W+SEQ_W] == '0)
		else $error("marked fraction non-zero without window close");

endmodule

bind dctcp_alpha_estimator dctcp_ae_chk u_dctcp_ae_chk (.*);
